[hw/rtl/signed_int_to_decimal_ascii_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal ASCII block
// Checks are sampled on clock and switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// same-cycle implication
`define SITDA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SITDA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/sitda_pkg.sv]
// ----------------------------------------------------------------------------
// sitda_pkg
// Widths, character codes and shared types for the integer to ASCII block.
// ----------------------------------------------------------------------------
package sitda_pkg;

   localparam int BinWidth    = 64;
   localparam int DigitWidth  = 4;
   localparam int BcdDigits   = 20;
   localparam int BcdWidth    = BcdDigits * DigitWidth;
   localparam int BitsPerStep = 4;
   localparam int ConvSteps   = BinWidth / BitsPerStep;
   localparam int StepWidth   = $clog2(ConvSteps);
   localparam int CntWidth    = $clog2(BcdDigits + 1);
   localparam int CharWidth   = 6;

   localparam logic [CharWidth-1:0] CodeZero  = 6'd48;
   localparam logic [CharWidth-1:0] CodeMinus = 6'd45;

   // one character handed from the sequencer to the output register
   typedef struct packed {
      logic                 vld;
      logic [CharWidth-1:0] code;
      logic                 last;
   } sitda_char_type;

endpackage

[hw/rtl/sitda_req_if.sv]
// ----------------------------------------------------------------------------
// sitda_req_if
// Input channel: one signed 64-bit integer per word.
// ----------------------------------------------------------------------------
interface sitda_req_if import sitda_pkg::*;;

   logic                       valid;
   logic                       ready;
   logic signed [BinWidth-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);

endinterface

[hw/rtl/sitda_rsp_if.sv]
// ----------------------------------------------------------------------------
// sitda_rsp_if
// Result channel: one ASCII character per word, last flag on the final one.
// ----------------------------------------------------------------------------
interface sitda_rsp_if import sitda_pkg::*;;

   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] char_code;
   logic                 last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);

endinterface

[hw/rtl/sitda_dabble.sv]
// ----------------------------------------------------------------------------
// sitda_dabble
// Shift-and-add-3 unit: folds four binary bits, MSB first, into a BCD word.
// ----------------------------------------------------------------------------
module sitda_dabble import sitda_pkg::*; (
   input  logic [BcdWidth-1:0]    bcd_in,
   input  logic [BitsPerStep-1:0] bits_in,
   output logic [BcdWidth-1:0]    bcd_out
);

   always_comb begin
      logic [BcdWidth-1:0] acc;
      acc = bcd_in;
      for (int s = 0; s < BitsPerStep; s++) begin
         // digits are independent lanes; only the bit steps chain
         for (int d = 0; d < BcdDigits; d++) begin
            if (acc[d*DigitWidth +: DigitWidth] >= 4'd5) begin
               acc[d*DigitWidth +: DigitWidth] = acc[d*DigitWidth +: DigitWidth] + 4'd3;
            end
         end
         acc = {acc[BcdWidth-2:0], bits_in[BitsPerStep-1-s]};
      end
      bcd_out = acc;
   end

endmodule

[hw/rtl/sitda_seq.sv]
// ----------------------------------------------------------------------------
// sitda_seq
// Sequencer: magnitude, BCD conversion through the one reused dabble unit,
// leading-zero skip and character emission, MSD first.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_top_macros.svh"

module sitda_seq import sitda_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [BinWidth-1:0] value_in,
   input  logic                out_free,
   output logic                idle,
   output sitda_char_type      emit
);

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StConv = 3'd1;
   localparam logic [2:0] StSign = 3'd2;
   localparam logic [2:0] StSkip = 3'd3;
   localparam logic [2:0] StEmit = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [BinWidth-1:0]  bin_ff, bin_in;
   logic [BcdWidth-1:0]  bcd_ff, bcd_in;
   logic                 neg_ff, neg_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic [StepWidth-1:0] step_ff, step_in;
   logic [BcdWidth-1:0]  dabble_out;
   logic [DigitWidth-1:0] top_digit;

   sitda_dabble u_dabble (
      .bcd_in  (bcd_ff),
      .bits_in (bin_ff[BinWidth-1 -: BitsPerStep]),
      .bcd_out (dabble_out)
   );

   assign top_digit = bcd_ff[BcdWidth-1 -: DigitWidth];
   assign idle      = (state_ff == StIdle);

   always_comb begin
      state_in  = state_ff;
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      step_in   = step_ff;
      emit.vld  = 1'b0;
      emit.code = CodeZero + CharWidth'(top_digit);
      emit.last = (cnt_ff == CntWidth'(1));
      case (state_ff)
         StIdle: begin
            if (start) begin
               neg_in   = value_in[BinWidth-1];
               // most negative value wraps to 2^63, correct as unsigned
               bin_in   = value_in[BinWidth-1] ? (~value_in + BinWidth'(1)) : value_in;
               bcd_in   = '0;
               step_in  = '0;
               cnt_in   = CntWidth'(BcdDigits);
               state_in = StConv;
            end
         end
         StConv: begin
            bcd_in  = dabble_out;
            bin_in  = bin_ff << BitsPerStep;
            step_in = step_ff + StepWidth'(1);
            if (step_ff == StepWidth'(ConvSteps - 1)) begin
               state_in = neg_ff ? StSign : StSkip;
            end
         end
         StSign: begin
            if (out_free) begin
               emit.vld  = 1'b1;
               emit.code = CodeMinus;
               emit.last = 1'b0;
               state_in  = StSkip;
            end
         end
         StSkip: begin
            // drop leading zeros, keep at least one digit
            if (top_digit == '0 && cnt_ff != CntWidth'(1)) begin
               bcd_in = bcd_ff << DigitWidth;
               cnt_in = cnt_ff - CntWidth'(1);
            end else begin
               state_in = StEmit;
            end
         end
         StEmit: begin
            if (out_free) begin
               emit.vld = 1'b1;
               bcd_in   = bcd_ff << DigitWidth;
               cnt_in   = cnt_ff - CntWidth'(1);
               if (cnt_ff == CntWidth'(1)) begin
                  state_in = StIdle;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      step_ff <= step_in;
   end

   `SITDA_ASSERT_SAME(a_emit_state, emit.vld, state_ff == StSign || state_ff == StEmit, "character emitted outside sign or digit phase")
   `SITDA_ASSERT_SAME(a_sign_neg, state_ff == StSign, neg_ff, "minus sign phase for a non-negative value")
   `SITDA_ASSERT_NEXT(a_start_conv, start && idle, state_ff == StConv && step_ff == '0, "accepted word did not start conversion")
   `SITDA_ASSERT_NEXT(a_last_idle, emit.vld && emit.last, state_ff == StIdle, "sequencer not idle after final character")
   `SITDA_ASSERT_SAME(a_top_zero, state_ff == StSkip && cnt_ff == CntWidth'(BcdDigits), top_digit == '0, "BCD overflow into spare top digit")

endmodule

[hw/rtl/signed_int_to_decimal_ascii_top.sv]
// Sequence: a word is accepted in the idle state and runs through 16 conversion steps; a
//    negative word's minus sign is then registered, the leading zeros are skipped in a sweep
//    over the 20 BCD digits and the digits follow, one digit per cycle while the output is free.
// A new word is accepted only after the last character of the previous word is emitted.
// Reset: synchronous, active high; clears the sequencer state and the output valid.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Signed 64-bit integer to decimal ASCII text, one character per output word.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top import sitda_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   sitda_req_if.sink    req_ch,
   sitda_rsp_if.source  rsp_ch
);

   logic                 rsp_valid_ff;
   logic [CharWidth-1:0] rsp_code_ff;
   logic                 rsp_last_ff;
   logic                 out_free;
   logic                 idle;
   sitda_char_type       emit;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   sitda_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_ch.valid),
      .value_in (req_ch.value),
      .out_free (out_free),
      .idle     (idle),
      .emit     (emit)
   );

   assign req_ch.ready = idle;

   // output register parts the result channel from the sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.vld) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit.vld) begin
         rsp_code_ff <= emit.code;
         rsp_last_ff <= emit.last;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.char_code = rsp_code_ff;
   assign rsp_ch.last      = rsp_last_ff;

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Converter test: directed and random signed 64-bit words are sent, the
// expected decimal text for each is queued and every character is checked.
// ----------------------------------------------------------------------------
module tb import sitda_pkg::*;;

   localparam int CycleLimit = 800000;
   localparam int LongHold   = 500;

   // expected characters for every accepted word, oldest first
   class text_scoreboard;
      logic [CharWidth-1:0] pending_codes[$];
      logic                 pending_lasts[$];
      int                   errors = 0;

      task report(input string what);
         $display("MISMATCH at %0t: %s", $time, what);
         errors++;
      endtask

      function void note_value(input logic signed [BinWidth-1:0] v);
         logic [BinWidth-1:0] mag;
         logic [3:0]          digits[$];
         mag = v[BinWidth-1] ? (~v + 1'b1) : v;
         do begin
            digits.push_back(4'(mag % 10));
            mag = mag / 10;
         end while (mag != 0);
         if (v[BinWidth-1]) begin
            pending_codes.push_back(CodeMinus);
            pending_lasts.push_back(1'b0);
         end
         for (int i = digits.size() - 1; i >= 0; i--) begin
            pending_codes.push_back(CodeZero + CharWidth'(digits[i]));
            pending_lasts.push_back(i == 0);
         end
      endfunction

      task check_char(input logic [CharWidth-1:0] code, input logic last);
         logic [CharWidth-1:0] want_code;
         logic                 want_last;
         if (pending_codes.size() == 0) begin
            report($sformatf("unexpected word char_code=%0d last=%0b", code, last));
         end else begin
            want_code = pending_codes.pop_front();
            want_last = pending_lasts.pop_front();
            if (code !== want_code)
               report($sformatf("char_code %0d, expected %0d", code, want_code));
            if (last !== want_last)
               report($sformatf("last %0b, expected %0b", last, want_last));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   int   cycles = 0;
   bit   no_idle = 0;
   bit   hold_off_req = 0;

   text_scoreboard board = new();

   sitda_req_if req_if();
   sitda_rsp_if rsp_if();

   signed_int_to_decimal_ascii_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pick_gap();
      return no_idle ? 0 : int'($urandom_range(0, 17));
   endfunction

   // half full-width random, a quarter spread magnitudes, a quarter near powers of ten
   function automatic logic signed [BinWidth-1:0] random_value();
      logic [BinWidth-1:0] r;
      logic [BinWidth-1:0] p;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: begin
            r = r >> $urandom_range(0, 63);
            if ($urandom_range(0, 1)) r = ~r + 1'b1;
         end
         1: begin
            p = 1;
            repeat ($urandom_range(0, 18)) p = p * 10;
            r = p + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) r = ~r + 1'b1;
         end
         default: ;
      endcase
      return r;
   endfunction

   // valid stays high across back-to-back words; only lowered for a gap
   task send_value(input logic signed [BinWidth-1:0] v);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.value <= v;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.note_value(v);
   endtask

   task take_chars();
      int stall;
      forever begin
         if (hold_off_req) begin
            hold_off_req = 0;
            rsp_if.ready <= 1'b0;
            repeat (LongHold) @(posedge clock);
         end
         stall = pick_gap();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         board.check_char(rsp_if.char_code, rsp_if.last);
      end
   endtask

   initial begin
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      take_chars();
   end

   initial begin
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      logic signed [BinWidth-1:0] directed[$];
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.value = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed = '{64'sd0, 64'sd1, -64'sd1, 64'sd9, 64'sd10, -64'sd10, 64'sd99,
                   -64'sd100, 64'sd999999999999999999, 64'sd1000000000000000000,
                   -64'sd1000000000000000000, -64'sd999999999999999999,
                   64'sh7FFF_FFFF_FFFF_FFFF, 64'sh8000_0000_0000_0000,
                   64'sh8000_0000_0000_0001, 64'sh7FFF_FFFF_FFFF_FFFE,
                   64'sh5555_5555_5555_5555, 64'shAAAA_AAAA_AAAA_AAAA};
      foreach (directed[i]) send_value(directed[i]);

      // phase 1 runs without gaps, phase 2 starts with a long output stall
      for (int phase = 0; phase < 4; phase++) begin
         no_idle = (phase == 1);
         if (phase == 2) hold_off_req = 1;
         repeat (90) send_value(random_value());
      end
      req_if.valid <= 1'b0;
      no_idle = 0;

      while (board.pending_codes.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      if (board.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
